[rtl/core/mdds_pkg.sv]
// mdds_pkg: shared types, register indexes and waveform codes of the dds tone generator
// no dependencies; imported by every module of the block
package mdds_pkg;

  localparam int WAVE_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_BPSK     = 3'd4;
  localparam int WAVE_COUNT = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY_HZ    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE       = 2'd2;

  localparam logic signed [15:0] FREQ_RESET = 16'sd1000;
  localparam logic [14:0] AMP_RESET = 15'd32767;
  localparam logic signed [31:0] FREQ_SCALE = 32'sd22368;
  localparam int FREQ_SHIFT = 14;
  localparam logic signed [17:0] STEP_MAX = 18'sd32767;
  localparam logic signed [17:0] STEP_MIN = -18'sd32767;

  // one classified tick between front and back
  typedef struct packed {
    logic [WAVE_W-1:0] kind;
    logic              neg;
    logic [15:0]       phase;
  } item_t;

  // hz to signed phase step, floor scaling, clamped, zero forced to one
  function automatic logic signed [15:0] calc_step(input logic signed [15:0] freq);
    logic signed [31:0] prod;
    logic signed [17:0] s;
    prod = 32'(freq) * FREQ_SCALE;
    s = 18'(prod >>> FREQ_SHIFT);
    if (s > STEP_MAX) begin
      s = STEP_MAX;
    end else if (s < STEP_MIN) begin
      s = STEP_MIN;
    end else if (s == 18'sd0) begin
      s = 18'sd1;
    end
    return s[15:0];
  endfunction

endpackage

[rtl/core/mdds_front.sv]
// mdds_front: accepts sample ticks, advances the selected phase accumulator and
// classifies the tick for the back end; depends on mdds_pkg
module mdds_front #(
  parameter int PHASE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_ready,
  input  logic                           bpsk_bit,
  input  logic [mdds_pkg::WAVE_W-1:0]    waveform_select,
  input  logic signed [15:0]             step,
  input  logic                           queue_full,
  output logic                           push,
  output mdds_pkg::item_t                push_item
);
  import mdds_pkg::*;

  logic [PHASE_BITS-1:0] acc [WAVE_COUNT];
  logic [PHASE_BITS-1:0] acc_sum;
  logic [PHASE_BITS-1:0] step_ext;
  logic [31:0]           step32;
  logic [PHASE_BITS+15:0] acc_pad;
  logic                  sel_ok;

  assign sel_ok = waveform_select < 3'(WAVE_COUNT);
  assign tick_ready = !queue_full;
  assign push = tick_valid && tick_ready;

  assign step32 = 32'(step);
  assign step_ext = step32[PHASE_BITS-1:0];
  assign acc_sum = sel_ok ? acc[waveform_select] + step_ext : '0;
  // top 16 bits of the accumulator, zero padded below for narrow accumulators
  assign acc_pad = {acc_sum, 16'b0};

  always_comb begin
    push_item.kind  = waveform_select;
    push_item.neg   = (waveform_select == WAVE_BPSK) && !bpsk_bit;
    push_item.phase = acc_pad[PHASE_BITS+15 -: 16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAVE_COUNT; i++) begin
        acc[i] <= '0;
      end
    end else if (push && sel_ok) begin
      acc[waveform_select] <= acc_sum;
    end
  end

endmodule

[rtl/core/mdds_queue.sv]
// mdds_queue: short fifo of classified ticks between front and back
// depends on mdds_pkg for the entry type
module mdds_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mdds_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mdds_pkg::item_t head_item
);
  import mdds_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

[rtl/core/mdds_back.sv]
// mdds_back: sine rom lookup, amplitude scaling and waveform shaping
// two registered stages ending in the output register; depends on mdds_pkg
module mdds_back #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mdds_pkg::item_t head_item,
  output logic            pop,
  input  logic [14:0]     amplitude,
  output logic            sample_valid,
  input  logic            sample_ready,
  output logic signed [15:0] sample
);
  import mdds_pkg::*;

  localparam int IW = (SINE_TABLE_ENTRIES > 1) ? $clog2(SINE_TABLE_ENTRIES) : 1;
  localparam longint unsigned NTAB = SINE_TABLE_ENTRIES;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  // q15 sine of entry idx over a full turn, quarter wave series in q30
  function automatic logic signed [15:0] rom_entry(input longint unsigned idx);
    longint unsigned f, quad, r, x, x2, t, d, v, q15;
    f = idx * 4;
    quad = (f / NTAB) & 64'd3;
    r = f % NTAB;
    if (quad[0]) begin
      r = NTAB - r;
    end
    x = (r * Q30_HALF_PI) / NTAB;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    d = ((x2 * t) >> 30) / 110;
    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d = ((x2 * t) >> 30) / 72;
    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d = ((x2 * t) >> 30) / 42;
    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d = ((x2 * t) >> 30) / 20;
    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d = ((x2 * t) >> 30) / 6;
    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    v = (x * t) >> 30;
    q15 = (v + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return quad[1] ? -16'(q15) : 16'(q15);
  endfunction

  logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];

  for (genvar i = 0; i < SINE_TABLE_ENTRIES; i++) begin : g_rom
    assign sine_rom[i] = rom_entry(longint'(i));
  end

  logic [16+IW-1:0] idx_prod;
  logic [IW-1:0]    rom_addr;

  // stage 1: rom read
  logic               s1_valid;
  item_t              s1_item;
  logic signed [15:0] s1_rom;

  logic out_free;
  logic s1_ready;
  logic s1_adv;

  logic signed [15:0] sine_val;
  logic signed [15:0] amp_s;
  logic signed [31:0] scaled;
  logic signed [15:0] p;
  logic signed [16:0] abs_p;
  logic signed [16:0] tri_val;
  logic signed [15:0] sample_next;

  assign idx_prod = (16 + IW)'(head_item.phase) * (16 + IW)'(SINE_TABLE_ENTRIES);
  assign rom_addr = idx_prod[16+IW-1:16];

  assign out_free = !sample_valid || sample_ready;
  assign s1_adv = s1_valid && out_free;
  assign s1_ready = !s1_valid || out_free;
  assign pop = head_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= head_item;
      s1_rom  <= sine_rom[rom_addr];
    end
  end

  // stage 2: shaping into the output register
  assign sine_val = s1_item.neg ? -s1_rom : s1_rom;
  assign amp_s = {1'b0, amplitude};
  assign scaled = 32'(sine_val) * 32'(amp_s);
  assign p = s1_item.phase;
  assign abs_p = p[15] ? -17'(p) : 17'(p);
  // most negative phase gives -1
  assign tri_val = 17'sd32767 - abs_p;

  always_comb begin
    case (s1_item.kind)
      WAVE_SINE, WAVE_BPSK: sample_next = scaled[30:15];
      WAVE_SQUARE:          sample_next = (p <= 16'sd0) ? amp_s : -amp_s;
      WAVE_SAW:             sample_next = p;
      WAVE_TRIANGLE:        sample_next = tri_val[15:0];
      default:              sample_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_free) begin
      sample_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sample <= sample_next;
    end
  end

endmodule

[rtl/core/multi_waveform_dds_generator_unit.sv]
// multi_waveform_dds_generator_unit: top level of the multi waveform dds tone generator
// holds the configuration registers; uses mdds_pkg, mdds_front, mdds_queue, mdds_back
//
// usage:
//   each transaction on the tick channel (tick_valid/tick_ready, payload bpsk_bit) is
//   one audio sample tick; each produces exactly one transaction on the sample channel
//   (sample_valid/sample_ready, payload sample), in order.
//   the configuration port writes waveform_select, frequency_hz and amplitude by index
//   with cfg_we; write only while no tick is in flight. the frequency is turned into a
//   phase step as it is written. index 3 is ignored.
//   a tick passes through the queue, the stage 1 rom register and the output register.
//   throughput: one tick per cycle while the queue is not full; the front adds the step to
//   one accumulator each cycle and the back registers the sine rom read and then scales it.
//   a four-entry queue parts front and back; when the receiver stalls, the back holds
//   its output register and the queue fills before tick_ready drops.
//   reset (rst, synchronous): all phase accumulators cleared, queue and pipeline
//   emptied, registers back to sine, 1000 hz and full amplitude.
module multi_waveform_dds_generator_unit #(
  parameter int PHASE_BITS = 16,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic                                bpsk_bit,
  output logic                                sample_valid,
  input  logic                                sample_ready,
  output logic signed [15:0]                  sample,
  input  logic                                cfg_we,
  input  logic [mdds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mdds_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mdds_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  logic [WAVE_W-1:0]  waveform_select;
  logic signed [15:0] step;
  logic [14:0]        amplitude;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= WAVE_SINE;
      step            <= calc_step(FREQ_RESET);
      amplitude       <= AMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVEFORM_SELECT: waveform_select <= cfg_data[WAVE_W-1:0];
        REG_FREQUENCY_HZ:    step <= calc_step(cfg_data);
        REG_AMPLITUDE:       amplitude <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  mdds_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .tick_valid     (tick_valid),
    .tick_ready     (tick_ready),
    .bpsk_bit       (bpsk_bit),
    .waveform_select(waveform_select),
    .step           (step),
    .queue_full     (queue_full),
    .push           (push),
    .push_item      (push_item)
  );

  mdds_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  mdds_back #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .amplitude   (amplitude),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample)
  );

endmodule

[dv/multi_waveform_dds_generator_unit_tb.sv]
// testbench for multi_waveform_dds_generator_unit: a directed table, then random phases
// that reprogram the tone registers and run ticks, checked against an in-bench predictor
// depends on mdds_pkg and multi_waveform_dds_generator_unit only
`timescale 1ns / 100ps

module multi_waveform_dds_generator_unit_tb;
  import mdds_pkg::*;

  localparam int SINE_ENTRIES = 1024;
  localparam int HZ_SCALE = 22368;
  localparam int HZ_SHIFT = 14;
  localparam int STEP_LIMIT = 32767;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam int RANDOM_TICKS = 1950;
  localparam int MAX_PRINTED = 40;

  localparam logic [WAVE_W-1:0] WAVE_SPARE5 = 3'd5;
  localparam logic [WAVE_W-1:0] WAVE_SPARE6 = 3'd6;
  localparam logic [WAVE_W-1:0] WAVE_SPARE7 = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic tick_valid;
  logic tick_ready;
  logic bpsk_bit;
  logic sample_valid;
  logic sample_ready;
  logic signed [15:0] sample;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  typedef struct {
    int                 n;
    logic signed [15:0] val;
  } pending_t;

  typedef struct {
    logic [WAVE_W-1:0]  wave;
    logic signed [15:0] freq;
    logic [14:0]        amp;
    bit                 sym;
    bit                 typed;
    logic signed [15:0] want;
  } stim_row_t;

  pending_t pending_samples[$];
  stim_row_t stim_rows[$];

  // predictor state: registers, per-waveform phase and the q15 sine rom
  logic [WAVE_W-1:0] cur_wave;
  logic signed [15:0] cur_freq;
  logic [14:0] cur_amp;
  logic [15:0] phase_acc [WAVE_COUNT];
  int sine_q15 [SINE_ENTRIES];

  int mismatch_count = 0;
  int ticks_sent = 0;
  int samples_seen = 0;
  int items_left = 0;

  multi_waveform_dds_generator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .bpsk_bit     (bpsk_bit),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("multi_waveform_dds_generator_unit: mismatch");
    $finish;
  end

  // sin over a quarter wave, q30 in and out, odd series up to x^11
  function automatic longint unsigned quarter_sine(input longint unsigned x);
    longint unsigned x2, t, d, dv;
    int k;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (k = 0; k < 5; k++) begin
      dv = 64'((11 - 2 * k) * (10 - 2 * k));
      d = ((x2 * t) >> 30) / dv;
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    return (x * t) >> 30;
  endfunction

  function automatic int sine_entry(input int idx);
    longint unsigned f, quad, r, x, v, q15;
    f = 64'(idx) * 4;
    quad = (f / SINE_ENTRIES) & 64'd3;
    r = f % SINE_ENTRIES;
    if (quad[0]) begin
      r = SINE_ENTRIES - r;
    end
    x = (r * Q30_HALF_PI) / SINE_ENTRIES;
    v = quarter_sine(x);
    q15 = (v + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return quad[1] ? -int'(q15) : int'(q15);
  endfunction

  function automatic logic signed [15:0] freq_to_step(input logic signed [15:0] f);
    longint s;
    s = (longint'(f) * HZ_SCALE) >>> HZ_SHIFT;
    if (s > STEP_LIMIT) begin
      s = STEP_LIMIT;
    end else if (s < -STEP_LIMIT) begin
      s = -STEP_LIMIT;
    end else if (s == 0) begin
      s = 1;
    end
    return s[15:0];
  endfunction

  // advances the selected accumulator and forms this tick's sample
  function automatic logic signed [15:0] next_sample(input bit sym);
    logic [15:0] pu;
    int p, s, idx, res;
    res = 0;
    if (cur_wave < WAVE_COUNT) begin
      phase_acc[cur_wave] = phase_acc[cur_wave] + freq_to_step(cur_freq);
      pu = phase_acc[cur_wave];
      p = $signed(pu);
      idx = (int'(pu) * SINE_ENTRIES) >>> 16;
      case (cur_wave)
        WAVE_SINE, WAVE_BPSK: begin
          s = sine_q15[idx];
          if (cur_wave == WAVE_BPSK && !sym) begin
            s = -s;
          end
          res = (s * int'(cur_amp)) >>> 15;
        end
        WAVE_SQUARE: res = (p <= 0) ? int'(cur_amp) : -int'(cur_amp);
        WAVE_SAW: res = p;
        default: res = 32767 - ((p < 0) ? -p : p);
      endcase
    end
    return res[15:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string what, input int n,
                                 input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("ERROR %0t tick %0d %s: got %0d want %0d", $realtime, n, what, got, want);
    end
  endtask

  task automatic add_row(input logic [WAVE_W-1:0] wave, input logic signed [15:0] freq,
                         input logic [14:0] amp, input bit sym, input bit typed,
                         input logic signed [15:0] want);
    stim_row_t row;
    row.wave = wave;
    row.freq = freq;
    row.amp = amp;
    row.sym = sym;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic send_tick(input bit sym, input int gap, input bit typed,
                           input logic signed [15:0] want);
    pending_t e;
    tick_valid <= 1'b1;
    bpsk_bit <= sym;
    @(posedge clk);
    while (!tick_ready) begin
      @(posedge clk);
    end
    e.n = ticks_sent;
    e.val = next_sample(sym);
    if (typed) begin
      e.val = want;
    end
    pending_samples.push_back(e);
    ticks_sent++;
    if (gap > 0) begin
      tick_valid <= 1'b0;
      bpsk_bit <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_samples();
    tick_valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_WAVEFORM_SELECT: cur_wave = data[WAVE_W-1:0];
      REG_FREQUENCY_HZ: cur_freq = $signed(data);
      REG_AMPLITUDE: cur_amp = data[14:0];
      default: ;
    endcase
  endtask

  // only once the tick pipeline has emptied
  task automatic reconfigure(input logic [WAVE_W-1:0] w, input logic signed [15:0] f,
                             input logic [14:0] a, input bit write_all, input bit junk,
                             input bit spare_write);
    bit any;
    logic [12:0] hi;
    drain_samples();
    any = 1'b0;
    hi = junk ? 13'($urandom) : 13'd0;
    if (write_all || w != cur_wave) begin
      write_reg(REG_WAVEFORM_SELECT, {hi, w});
      any = 1'b1;
    end
    if (write_all || f != cur_freq) begin
      write_reg(REG_FREQUENCY_HZ, f);
      any = 1'b1;
    end
    if (write_all || a != cur_amp) begin
      write_reg(REG_AMPLITUDE, {hi[0], a});
      any = 1'b1;
    end
    if (spare_write) begin
      write_reg(REG_SPARE, 16'($urandom));
      any = 1'b1;
    end
    if (any) begin
      cfg_we <= 1'b0;
      repeat (2) @(posedge clk);
    end
  endtask

  // sample side: check each transaction and pace sample_ready
  initial begin
    int stall_left, calm_left, hold_left, holds_done;
    bit nxt;
    pending_t e;
    stall_left = 0;
    calm_left = 0;
    hold_left = 0;
    holds_done = 0;
    sample_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sample_valid && sample_ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("sample with no tick pending", -1, sample, 16'sd0);
        end else begin
          e = pending_samples.pop_front();
          if (sample !== e.val) begin
            report_mismatch("sample", e.n, sample, e.val);
          end
        end
        samples_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (holds_done < 2 && samples_seen >= 500 + 800 * holds_done &&
                   items_left >= 20 && tick_valid) begin
        // long back-pressure while ticks keep coming, so the queue fills
        hold_left = 150;
        holds_done++;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        nxt = 1'b1;
      end else begin
        nxt = 1'b1;
        if ($urandom_range(0, 99) < 4) begin
          calm_left = $urandom_range(50, 200);
        end else begin
          stall_left = idle_len();
          nxt = (stall_left == 0);
        end
      end
      sample_ready <= nxt;
    end
  end

  initial begin
    int n, gap_cut, r, random_sent;
    bit quiet, do_all;
    logic [WAVE_W-1:0] w;
    logic signed [15:0] f;
    logic [14:0] a;
    rst <= 1'b1;
    tick_valid <= 1'b0;
    bpsk_bit <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WAVEFORM_SELECT;
    cfg_data <= 16'd0;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      sine_q15[i] = sine_entry(i);
    end
    for (int i = 0; i < WAVE_COUNT; i++) begin
      phase_acc[i] = 16'd0;
    end
    cur_wave = WAVE_SINE;
    cur_freq = FREQ_RESET;
    cur_amp = AMP_RESET;

    // first rows run on the reset register values
    add_row(WAVE_SINE, 16'sd1000, 15'd32767, 1'b1, 1'b0, 16'sd0);
    add_row(WAVE_SINE, 16'sd1000, 15'd32767, 1'b0, 1'b0, 16'sd0);
    add_row(WAVE_SPARE5, 16'sd1000, 15'd32767, 1'b1, 1'b1, 16'sd0);
    add_row(WAVE_SPARE6, 16'sd1000, 15'd32767, 1'b0, 1'b1, 16'sd0);
    add_row(WAVE_SPARE7, 16'sd1000, 15'd32767, 1'b1, 1'b1, 16'sd0);
    add_row(WAVE_SAW, 16'sd32767, 15'd32767, 1'b1, 1'b1, 16'sd32767);
    add_row(WAVE_SAW, 16'sd32767, 15'd32767, 1'b0, 1'b1, -16'sd2);
    // zero step is forced to one
    add_row(WAVE_SAW, 16'sd0, 15'd32767, 1'b1, 1'b1, -16'sd1);
    add_row(WAVE_SAW, 16'sd0, 15'd32767, 1'b1, 1'b1, 16'sd0);
    add_row(WAVE_SAW, -16'sd32768, 15'd32767, 1'b0, 1'b1, -16'sd32767);
    add_row(WAVE_SAW, -16'sd1, 15'd32767, 1'b1, 1'b0, 16'sd0);
    add_row(WAVE_TRIANGLE, 16'sd32767, 15'd32767, 1'b1, 1'b1, 16'sd0);
    // triangle at the most negative phase
    add_row(WAVE_TRIANGLE, 16'sd0, 15'd32767, 1'b1, 1'b1, -16'sd1);
    add_row(WAVE_SQUARE, 16'sd32767, 15'd32767, 1'b1, 1'b1, -16'sd32767);
    add_row(WAVE_SQUARE, 16'sd0, 15'd32767, 1'b0, 1'b1, 16'sd32767);
    add_row(WAVE_SQUARE, 16'sd32767, 15'd32767, 1'b1, 1'b1, 16'sd32767);
    add_row(WAVE_SQUARE, 16'sd0, 15'd32767, 1'b1, 1'b1, 16'sd32767);
    add_row(WAVE_SQUARE, 16'sd0, 15'd0, 1'b1, 1'b1, 16'sd0);
    add_row(WAVE_SINE, 16'sd32767, 15'd0, 1'b1, 1'b1, 16'sd0);
    add_row(WAVE_SINE, 16'sd32767, 15'd32767, 1'b1, 1'b0, 16'sd0);
    add_row(WAVE_BPSK, 16'sd12000, 15'd32767, 1'b1, 1'b0, 16'sd0);
    add_row(WAVE_BPSK, 16'sd12000, 15'd32767, 1'b0, 1'b0, 16'sd0);
    add_row(WAVE_BPSK, -16'sd32768, 15'd1, 1'b0, 1'b0, 16'sd0);
    add_row(WAVE_SINE, -16'sd32768, 15'd32767, 1'b1, 1'b0, 16'sd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].wave != cur_wave || stim_rows[i].freq != cur_freq ||
          stim_rows[i].amp != cur_amp) begin
        reconfigure(stim_rows[i].wave, stim_rows[i].freq, stim_rows[i].amp, 1'b0, 1'b0,
                    1'b0);
      end
      send_tick(stim_rows[i].sym, $urandom_range(0, 2), stim_rows[i].typed,
                stim_rows[i].want);
    end

    random_sent = 0;
    while (random_sent < RANDOM_TICKS) begin
      w = cur_wave;
      f = cur_freq;
      a = cur_amp;
      if ($urandom_range(0, 9) < 6) begin
        w = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: f = 16'sd32767;
          1: f = -16'sd32768;
          2: f = 16'sd0;
          3: f = 16'($urandom_range(0, 4)) - 16'sd2;
          4, 5: f = $urandom_range(0, 1) ? 16'($urandom_range(20, 6000))
                                         : -16'($urandom_range(20, 6000));
          default: f = 16'($urandom);
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 9);
        a = (r == 0) ? 15'd0 : (r == 1) ? 15'd32767 : (r == 2) ? 15'd1 : 15'($urandom);
      end
      do_all = ($urandom_range(0, 3) == 0);
      reconfigure(w, f, a, do_all, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);

      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 160) : $urandom_range(8, 70);
      quiet = ($urandom_range(0, 3) == 0);
      gap_cut = 0;
      for (int i = 0; i < n; i++) begin
        items_left = n - i;
        gap_cut = quiet ? 0 : idle_len();
        send_tick(1'($urandom), gap_cut, 1'b0, 16'sd0);
      end
      items_left = 0;
      random_sent += n;
    end

    drain_samples();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multi_waveform_dds_generator_unit: match");
    end else begin
      $display("multi_waveform_dds_generator_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mdds_pkg.sv
rtl/core/mdds_front.sv
rtl/core/mdds_queue.sv
rtl/core/mdds_back.sv
rtl/core/multi_waveform_dds_generator_unit.sv
dv/multi_waveform_dds_generator_unit_tb.sv
